// ===== hw/rtl/rgbp_pkg.sv =====
// Shared types and constants for the two-LED pattern generator.
package rgbp_pkg;

   typedef enum logic [2:0] {
      MODE_OFF          = 3'd0,
      MODE_RED_FADE     = 3'd1,
      MODE_GREEN_FADE   = 3'd2,
      MODE_GREEN_BLINK  = 3'd3,
      MODE_CYAN_FADE    = 3'd4,
      MODE_YELLOW_FADE  = 3'd5,
      MODE_PURPLE_BLINK = 3'd6,
      MODE_BLUE_BLINK   = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      CSR_FAST_FADE_PERIOD   = 3'd0,
      CSR_SLOW_FADE_PERIOD   = 3'd1,
      CSR_LONG_BLINK_ON      = 3'd2,
      CSR_LONG_BLINK_PERIOD  = 3'd3,
      CSR_SHORT_BLINK_ON     = 3'd4,
      CSR_SHORT_BLINK_PERIOD = 3'd5
   } csr_index_type;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int FADE_WIDTH      = 8;
   localparam int BLINK_WIDTH     = 16;

   localparam logic [7:0] LEVEL_TOP      = 8'd254;
   localparam logic [7:0] LEVEL_BOTTOM   = 8'd1;
   localparam logic [7:0] BLINK_ON_LEVEL = 8'd254;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } colour_type;

   localparam colour_type BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};

   typedef struct packed {
      logic [FADE_WIDTH-1:0]  fast_fade_period;
      logic [FADE_WIDTH-1:0]  slow_fade_period;
      logic [BLINK_WIDTH-1:0] long_blink_on;
      logic [BLINK_WIDTH-1:0] long_blink_period;
      logic [BLINK_WIDTH-1:0] short_blink_on;
      logic [BLINK_WIDTH-1:0] short_blink_period;
   } cfg_type;

   typedef struct packed {
      logic     tick;
      logic     load;
      mode_type mode;
   } led_ctl_type;

endpackage

// ===== hw/rtl/rgb_led_breathing_blink_pattern.sv =====
// Top level of the two-LED breathing and blink pattern generator.
// Usage:
//   req channel: one word per item. tuser is the kind (0 = one millisecond
//   tick, 1 = load new modes); tdata carries the two new modes.
//   rsp channel: one word per accepted request, holding both LED colours.
//   csr channel: write index and data of a configuration register; always
//   ready, writes take effect on the next cycle. Write only while idle.
// Output: the response word of an accepted request is loaded into the
//   output register at the edge that accepts it.
// Throughput: one request per cycle unless a response stalls; all pattern
//   work is one pass of compare and increment logic per LED between state and output regs.
// Stall: while a response waits and rsp_tready is low, req_tready drops;
//   the output register holds the word and no state advances.
// Reset: modes off, counters and levels zero, fade direction rising,
//   colours black, configuration at its defaults; no response is pending.
module rgb_led_breathing_blink_pattern
   import rgbp_pkg::*;
#(
   parameter int TIME_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,  // new_mode_first[2:0], new_mode_second[5:3]
   input  logic                       req_tuser,  // kind[0]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [47:0]                rsp_tdata,  // first_red, first_green, first_blue,
                                                  // second_red, second_green, second_blue
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type     cfg_ff;
   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff;
   logic        req_accept;
   led_ctl_type ctl_first, ctl_second;
   colour_type  colour_first_in, colour_second_in;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      ctl_first.tick  = req_accept && !req_tuser;
      ctl_first.load  = req_accept && req_tuser;
      ctl_first.mode  = mode_type'(req_tdata[2:0]);
      ctl_second.tick = ctl_first.tick;
      ctl_second.load = ctl_first.load;
      ctl_second.mode = mode_type'(req_tdata[5:3]);
   end

   rgbp_led_unit #(.TIME_WIDTH(TIME_WIDTH)) u_led_first (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_first),
      .cfg       (cfg_ff),
      .colour_in (colour_first_in)
   );

   rgbp_led_unit #(.TIME_WIDTH(TIME_WIDTH)) u_led_second (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_second),
      .cfg       (cfg_ff),
      .colour_in (colour_second_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_fade_period   <= 8'd1;
         cfg_ff.slow_fade_period   <= 8'd10;
         cfg_ff.long_blink_on      <= 16'd500;
         cfg_ff.long_blink_period  <= 16'd700;
         cfg_ff.short_blink_on     <= 16'd200;
         cfg_ff.short_blink_period <= 16'd300;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FAST_FADE_PERIOD:   cfg_ff.fast_fade_period   <= csr_data[FADE_WIDTH-1:0];
            CSR_SLOW_FADE_PERIOD:   cfg_ff.slow_fade_period   <= csr_data[FADE_WIDTH-1:0];
            CSR_LONG_BLINK_ON:      cfg_ff.long_blink_on      <= csr_data;
            CSR_LONG_BLINK_PERIOD:  cfg_ff.long_blink_period  <= csr_data;
            CSR_SHORT_BLINK_ON:     cfg_ff.short_blink_on     <= csr_data;
            CSR_SHORT_BLINK_PERIOD: cfg_ff.short_blink_period <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= {colour_second_in.blue, colour_second_in.green, colour_second_in.red,
                         colour_first_in.blue, colour_first_in.green, colour_first_in.red};
      end
   end

endmodule

// ===== hw/rtl/rgbp_led_unit.sv =====
// Pattern state and next-colour logic for one RGB LED.
module rgbp_led_unit
   import rgbp_pkg::*;
#(
   parameter int TIME_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  led_ctl_type ctl,
   input  cfg_type     cfg,
   output colour_type  colour_in
);

   localparam int CMP_WIDTH = (TIME_WIDTH > BLINK_WIDTH) ? TIME_WIDTH : BLINK_WIDTH;

   mode_type              mode_ff;
   logic [TIME_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [7:0]            level_ff, level_in;
   logic                  rising_ff, rising_in;
   colour_type            colour_ff;

   logic [TIME_WIDTH-1:0] elapsed_inc;
   logic [CMP_WIDTH-1:0]  elapsed_cmp;
   logic [CMP_WIDTH-1:0]  fade_period;
   logic [CMP_WIDTH-1:0]  blink_on;
   logic [CMP_WIDTH-1:0]  blink_period;
   logic                  fade_go;
   logic                  rising_step;
   logic [7:0]            level_step;
   colour_type            blink_colour;
   colour_type            tick_colour;

   always_comb begin
      elapsed_inc = (&elapsed_ff) ? elapsed_ff : elapsed_ff + 1'b1;
      elapsed_cmp = CMP_WIDTH'(elapsed_inc);

      fade_period = (mode_ff == MODE_RED_FADE) ? CMP_WIDTH'(cfg.fast_fade_period)
                                                : CMP_WIDTH'(cfg.slow_fade_period);
      fade_go     = elapsed_cmp > fade_period;

      priority if (level_ff >= LEVEL_TOP) begin
         rising_step = 1'b0;
      end else if (level_ff <= LEVEL_BOTTOM) begin
         rising_step = 1'b1;
      end else begin
         rising_step = rising_ff;
      end
      level_step = rising_step ? level_ff + 8'd1 : level_ff - 8'd1;

      if (mode_ff == MODE_PURPLE_BLINK) begin
         blink_on     = CMP_WIDTH'(cfg.short_blink_on);
         blink_period = CMP_WIDTH'(cfg.short_blink_period);
         blink_colour = '{red: BLINK_ON_LEVEL, green: 8'd0, blue: BLINK_ON_LEVEL};
      end else begin
         blink_on     = CMP_WIDTH'(cfg.long_blink_on);
         blink_period = CMP_WIDTH'(cfg.long_blink_period);
         blink_colour = (mode_ff == MODE_GREEN_BLINK)
                        ? colour_type'{red: 8'd0, green: BLINK_ON_LEVEL, blue: 8'd0}
                        : colour_type'{red: 8'd0, green: 8'd0, blue: BLINK_ON_LEVEL};
      end

      elapsed_in  = elapsed_inc;
      level_in    = level_ff;
      rising_in   = rising_ff;
      tick_colour = colour_ff;

      unique case (mode_ff)
         MODE_RED_FADE, MODE_GREEN_FADE, MODE_CYAN_FADE, MODE_YELLOW_FADE: begin
            if (fade_go) begin
               elapsed_in = '0;
               level_in   = level_step;
               rising_in  = rising_step;
               unique case (mode_ff)
                  MODE_RED_FADE:   tick_colour = '{red: level_step, green: 8'd0,
                                                   blue: 8'd0};
                  MODE_GREEN_FADE: tick_colour = '{red: 8'd0, green: level_step,
                                                   blue: 8'd0};
                  MODE_CYAN_FADE:  tick_colour = '{red: 8'd0, green: level_step,
                                                   blue: level_step};
                  default:         tick_colour = '{red: level_step, green: level_step,
                                                   blue: 8'd0};
               endcase
            end
         end
         MODE_GREEN_BLINK, MODE_PURPLE_BLINK, MODE_BLUE_BLINK: begin
            if (elapsed_cmp < blink_on) begin
               tick_colour = blink_colour;
            end
            if (elapsed_cmp > blink_on && elapsed_cmp < blink_period) begin
               tick_colour = BLACK;
            end
            if (elapsed_cmp > blink_period) begin
               elapsed_in = '0;
            end
         end
         MODE_OFF: begin
            tick_colour = BLACK;
         end
      endcase

      colour_in = ctl.tick ? tick_colour : colour_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_OFF;
         elapsed_ff <= '0;
         level_ff   <= '0;
         rising_ff  <= 1'b1;
         colour_ff  <= BLACK;
      end else begin
         if (ctl.load) begin
            mode_ff <= ctl.mode;
         end
         if (ctl.tick) begin
            elapsed_ff <= elapsed_in;
            level_ff   <= level_in;
            rising_ff  <= rising_in;
            colour_ff  <= tick_colour;
         end
      end
   end

endmodule

// ===== tb/rgbp_checker.sv =====
// Checker for the two-LED pattern generator: predicts each response word and compares it.
module rgbp_checker
   import rgbp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [7:0]                 req_tdata,  // new_mode_first[2:0], new_mode_second[5:3]
   input  logic                       req_tuser,  // kind[0]
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [47:0]                rsp_tdata,  // first_red, first_green, first_blue,
                                                  // second_red, second_green, second_blue
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output int                         outstanding,
   output int                         errors
);

   localparam int TIME_WIDTH = 16;

   typedef struct {
      mode_type              mode;
      logic [TIME_WIDTH-1:0] elapsed;
      logic [7:0]            level;
      logic                  rising;
      colour_type            colour;
   } lamp_state;

   lamp_state   lamp [2];
   cfg_type     cfg;
   logic [47:0] colour_q [$];
   int          fail_count = 0;
   int          word_count = 0;
   string       field_name [6] = '{"first_red", "first_green", "first_blue",
                                   "second_red", "second_green", "second_blue"};

   assign errors = fail_count;

   function automatic void restore_defaults();
      cfg.fast_fade_period   = 8'd1;
      cfg.slow_fade_period   = 8'd10;
      cfg.long_blink_on      = 16'd500;
      cfg.long_blink_period  = 16'd700;
      cfg.short_blink_on     = 16'd200;
      cfg.short_blink_period = 16'd300;
      for (int i = 0; i < 2; i++) begin
         lamp[i].mode    = MODE_OFF;
         lamp[i].elapsed = '0;
         lamp[i].level   = 8'd0;
         lamp[i].rising  = 1'b1;
         lamp[i].colour  = BLACK;
      end
   endfunction

   function automatic bit fade_due(int i, logic [7:0] period);
      if (lamp[i].elapsed <= TIME_WIDTH'(period))
         return 1'b0;
      lamp[i].elapsed = '0;
      if (lamp[i].level >= LEVEL_TOP)
         lamp[i].rising = 1'b0;
      else if (lamp[i].level <= LEVEL_BOTTOM)
         lamp[i].rising = 1'b1;
      lamp[i].level = lamp[i].rising ? lamp[i].level + 8'd1 : lamp[i].level - 8'd1;
      return 1'b1;
   endfunction

   function automatic void blink_rule(int i, logic [15:0] on_ms, logic [15:0] period,
                                      colour_type lit);
      logic [TIME_WIDTH-1:0] e;
      e = lamp[i].elapsed;
      if (e < TIME_WIDTH'(on_ms))
         lamp[i].colour = lit;
      if (e > TIME_WIDTH'(on_ms) && e < TIME_WIDTH'(period))
         lamp[i].colour = BLACK;
      if (e > TIME_WIDTH'(period))
         lamp[i].elapsed = '0;
   endfunction

   function automatic void advance_lamp(int i);
      logic [7:0] v;
      if (lamp[i].elapsed != '1)
         lamp[i].elapsed = lamp[i].elapsed + 1'b1;
      v = 8'd0;
      case (lamp[i].mode)
         MODE_RED_FADE: begin
            if (fade_due(i, cfg.fast_fade_period)) begin
               v = lamp[i].level;
               lamp[i].colour = {v, 8'd0, 8'd0};
            end
         end
         MODE_GREEN_FADE: begin
            if (fade_due(i, cfg.slow_fade_period)) begin
               v = lamp[i].level;
               lamp[i].colour = {8'd0, v, 8'd0};
            end
         end
         MODE_GREEN_BLINK:
            blink_rule(i, cfg.long_blink_on, cfg.long_blink_period,
                       {8'd0, BLINK_ON_LEVEL, 8'd0});
         MODE_CYAN_FADE: begin
            if (fade_due(i, cfg.slow_fade_period)) begin
               v = lamp[i].level;
               lamp[i].colour = {8'd0, v, v};
            end
         end
         MODE_YELLOW_FADE: begin
            if (fade_due(i, cfg.slow_fade_period)) begin
               v = lamp[i].level;
               lamp[i].colour = {v, v, 8'd0};
            end
         end
         MODE_PURPLE_BLINK:
            blink_rule(i, cfg.short_blink_on, cfg.short_blink_period,
                       {BLINK_ON_LEVEL, 8'd0, BLINK_ON_LEVEL});
         MODE_BLUE_BLINK:
            blink_rule(i, cfg.long_blink_on, cfg.long_blink_period,
                       {8'd0, 8'd0, BLINK_ON_LEVEL});
         default:
            lamp[i].colour = BLACK;
      endcase
   endfunction

   function automatic logic [47:0] colour_word();
      return {lamp[1].colour.blue, lamp[1].colour.green, lamp[1].colour.red,
              lamp[0].colour.blue, lamp[0].colour.green, lamp[0].colour.red};
   endfunction

   task automatic note_mismatch(string field, logic [7:0] want, logic [7:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("rsp word %0d: %s expected %0d got %0d", word_count, field, want, got);
   endtask

   initial restore_defaults();

   always @(posedge clock) begin
      logic [47:0] want;
      if (reset) begin
         restore_defaults();
         colour_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (colour_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("rsp word %0d: no word expected, got %h", word_count, rsp_tdata);
            end else begin
               want = colour_q.pop_front();
               for (int f = 0; f < 6; f++)
                  if (want[f*8 +: 8] !== rsp_tdata[f*8 +: 8])
                     note_mismatch(field_name[f], want[f*8 +: 8], rsp_tdata[f*8 +: 8]);
            end
            word_count++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_FAST_FADE_PERIOD:   cfg.fast_fade_period   = csr_data[7:0];
               CSR_SLOW_FADE_PERIOD:   cfg.slow_fade_period   = csr_data[7:0];
               CSR_LONG_BLINK_ON:      cfg.long_blink_on      = csr_data;
               CSR_LONG_BLINK_PERIOD:  cfg.long_blink_period  = csr_data;
               CSR_SHORT_BLINK_ON:     cfg.short_blink_on     = csr_data;
               CSR_SHORT_BLINK_PERIOD: cfg.short_blink_period = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               lamp[0].mode = mode_type'(req_tdata[2:0]);
               lamp[1].mode = mode_type'(req_tdata[5:3]);
            end else begin
               advance_lamp(0);
               advance_lamp(1);
            end
            colour_q.push_back(colour_word());
         end
      end
      outstanding <= colour_q.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the testbench for the two-LED pattern generator: clock, reset, stimulus and verdict.
module tb;
   import rgbp_pkg::*;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata  = 8'd0;  // new_mode_first[2:0], new_mode_second[5:3]
   logic                       req_tuser  = 1'b0;  // kind[0]
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [47:0]                rsp_tdata;          // first_red, first_green, first_blue,
                                                   // second_red, second_green, second_blue
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data   = '0;
   int                         outstanding;
   int                         errors;
   bit                         calm       = 1'b0;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock)
      rsp_tready <= calm || ($urandom_range(99) >= 19);

   rgb_led_breathing_blink_pattern #(
      .TIME_WIDTH (16)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   rgbp_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .errors      (errors)
   );

   task automatic send_word(input logic kind, input mode_type mf, input mode_type ms);
      while (!calm && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, ms, mf};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic tick();
      send_word(KIND_TICK, mode_type'($urandom_range(7)), mode_type'($urandom_range(7)));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(input logic [7:0] fast, input logic [7:0] slow,
                            input logic [15:0] lon, input logic [15:0] lper,
                            input logic [15:0] son, input logic [15:0] sper);
      settle();
      write_reg(CSR_FAST_FADE_PERIOD, {8'd0, fast});
      write_reg(CSR_SLOW_FADE_PERIOD, {8'd0, slow});
      write_reg(CSR_LONG_BLINK_ON, lon);
      write_reg(CSR_LONG_BLINK_PERIOD, lper);
      write_reg(CSR_SHORT_BLINK_ON, son);
      write_reg(CSR_SHORT_BLINK_PERIOD, sper);
      csr_valid <= 1'b0;
      repeat (2) @(negedge clock);
   endtask

   function automatic logic [15:0] pick(int unsigned top, int unsigned near);
      case ($urandom_range(5))
         0:       return 16'd0;
         1:       return 16'(top);
         default: return 16'($urandom_range(near));
      endcase
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // defaults, then every mode at tight timing
      tick();
      send_word(KIND_LOAD, MODE_RED_FADE, MODE_BLUE_BLINK);
      repeat (3) tick();
      configure(8'd0, 8'd1, 16'd2, 16'd4, 16'd1, 16'd3);
      for (int k = 1; k < 8; k++) begin
         send_word(KIND_LOAD, mode_type'(k), mode_type'(7 - k));
         repeat (2) tick();
      end

      // sweep the fade level up through its top turning point, no idling
      calm <= 1'b1;
      configure(8'd0, 8'd0, 16'd500, 16'd700, 16'd200, 16'd300);
      send_word(KIND_LOAD, MODE_RED_FADE, MODE_YELLOW_FADE);
      repeat (258) tick();
      calm <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         configure(8'(pick(255, 12)), 8'(pick(255, 12)), pick(65535, 40),
                   pick(65535, 40), pick(65535, 40), pick(65535, 40));
         send_word(KIND_LOAD, mode_type'($urandom_range(7)), mode_type'($urandom_range(7)));
         repeat (40) begin
            if ($urandom_range(99) < 12)
               send_word(KIND_LOAD, mode_type'($urandom_range(7)),
                         mode_type'($urandom_range(7)));
            else
               tick();
         end
      end

      settle();
      repeat (5) @(negedge clock);
      if (errors == 0 && outstanding == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   initial begin
      #8000000;
      $display("tb: errors");
      $finish;
   end

endmodule
